// ===== src/mped_pkg.sv =====
`default_nettype none

package mped_pkg;

    localparam int CHANNELS = 2;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHAN_W = 4;
    localparam int SAMPLE_W = 16;
    localparam int TOTAL_W = 24;
    localparam int SWEEP_W = 8;
    localparam int SPAN_W = SAMPLE_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = TOTAL_W;

    localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(CHANNELS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS = 2'd2;

    localparam logic [TOTAL_W-1:0] THRESHOLD_RESET = 24'd10;
    localparam logic [15:0] ENABLE_MASK_RESET = 16'h0001;
    localparam logic [SWEEP_W-1:0] SWEEPS_RESET = 8'd10;

    localparam logic signed [SAMPLE_W-1:0] PEAK_HIGH_RESET = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] PEAK_LOW_RESET = 16'sh7FFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;
    localparam logic [SWEEP_W-1:0] SWEEP_MAX = 8'hFF;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] peak_high;
        logic signed [SAMPLE_W-1:0] peak_low;
        logic [TOTAL_W-1:0]         total;
        logic                       flag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RD     = 5'b00010,
        S_CALC   = 5'b00100,
        S_REP_RD = 5'b01000,
        S_REP    = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// ===== src/mped_in_if.sv =====
`default_nettype none

interface mped_in_if;

    logic                                valid;
    logic                                ready;
    logic signed [mped_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);

endinterface

`default_nettype wire

// ===== src/mped_out_if.sv =====
`default_nettype none

interface mped_out_if;

    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic [mped_pkg::CHAN_W-1:0]           channel;
    logic signed [mped_pkg::SAMPLE_W-1:0] sample_out;
    logic [mped_pkg::TOTAL_W-1:0]          period_total;
    logic                                 detected;
    logic                                 last;

    modport source (
        output valid, output kind, output channel, output sample_out,
        output period_total, output detected, output last, input ready
    );
    modport sink (
        input valid, input kind, input channel, input sample_out,
        input period_total, input detected, input last, output ready
    );

endinterface

`default_nettype wire

// ===== src/multichannel_peak_energy_detector.sv =====
`default_nettype none

// Samples arrive for the channels in round-robin order, one beat per sample, and each
// sample yields one echo beat; the beat that completes the last sweep of a period also
// yields one report beat per channel with its peak-to-peak total and updated detect flag,
// after which totals and peaks restart. The per-channel state sits in one RAM with a
// registered read. A sample passes through accept with the RAM read, peak update, then
// accumulate and write-back, and the next sample is taken only after that; a period end
// adds a report pass that reads, reports and clears each entry in turn.
module multichannel_peak_energy_detector (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    mped_in_if.sink                                   samples,
    mped_out_if.source                                results,
    input  wire logic                                 cfg_we,
    input  wire logic [mped_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mped_pkg::CFG_DATA_W-1:0]      cfg_data
);

    mped_pkg::state_t state_reg, state_next;

    logic [mped_pkg::TOTAL_W-1:0]  thr_reg;
    logic [15:0]                   mask_reg;
    logic [mped_pkg::SWEEP_W-1:0]  sweeps_reg;

    logic [mped_pkg::CH_IDX_W-1:0] ptr_reg, ptr_next;
    logic [mped_pkg::SWEEP_W-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic [mped_pkg::CH_IDX_W-1:0] ch_reg, ch_next;
    logic [mped_pkg::CH_IDX_W-1:0] rep_idx_reg, rep_idx_next;
    logic signed [mped_pkg::SAMPLE_W-1:0] smp_reg, smp_next;
    logic [mped_pkg::CHANNELS-1:0] vld_reg, vld_next;
    logic                          rd_vld_reg;
    mped_pkg::entry_t              cur_reg, cur_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          kind_reg, kind_next;
    logic [mped_pkg::CHAN_W-1:0]   chan_reg, chan_next;
    logic signed [mped_pkg::SAMPLE_W-1:0] smp_out_reg, smp_out_next;
    logic [mped_pkg::TOTAL_W-1:0]  total_out_reg, total_out_next;
    logic                          det_reg, det_next;
    logic                          last_reg, last_next;

    logic                          mem_we;
    logic [mped_pkg::CH_IDX_W-1:0] mem_waddr, mem_raddr;
    logic [mped_pkg::ENTRY_W-1:0]  mem_rdata;
    mped_pkg::entry_t              mem_wdata, rd_entry, cleared;

    logic                          accept, out_free, wrap, period_end;
    logic [mped_pkg::SWEEP_W-1:0]  sweep_inc;
    logic signed [mped_pkg::SPAN_W-1:0] diff;
    logic [mped_pkg::SPAN_W-1:0]   span;
    logic [mped_pkg::TOTAL_W:0]    sum;
    logic [mped_pkg::TOTAL_W-1:0]  sum_sat;
    logic                          new_flag;

    mped_ram #(
        .WIDTH (mped_pkg::ENTRY_W),
        .DEPTH (mped_pkg::CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        cleared.peak_high = mped_pkg::PEAK_HIGH_RESET;
        cleared.peak_low  = mped_pkg::PEAK_LOW_RESET;
        cleared.total     = '0;
        cleared.flag      = 1'b0;
        rd_entry = rd_vld_reg ? mped_pkg::entry_t'(mem_rdata) : cleared;
    end

    assign accept    = samples.valid && samples.ready;
    assign out_free  = !out_valid_reg || results.ready;
    assign mem_raddr = (state_reg == mped_pkg::S_IDLE) ? ptr_reg : rep_idx_reg;

    assign wrap      = (ch_reg == mped_pkg::LAST_CH);
    assign sweep_inc = (sweep_cnt_reg == mped_pkg::SWEEP_MAX)
                       ? mped_pkg::SWEEP_MAX : sweep_cnt_reg + 1'b1;
    assign period_end = wrap && (sweep_inc >= sweeps_reg);

    assign diff = mped_pkg::SPAN_W'(cur_reg.peak_high) - mped_pkg::SPAN_W'(cur_reg.peak_low);
    assign span = (cur_reg.peak_high >= cur_reg.peak_low) ? mped_pkg::SPAN_W'(diff) : '0;
    assign sum  = {1'b0, cur_reg.total} + (mped_pkg::TOTAL_W + 1)'(span);
    assign sum_sat = sum[mped_pkg::TOTAL_W] ? mped_pkg::TOTAL_MAX
                     : sum[mped_pkg::TOTAL_W-1:0];

    always_comb
    begin
        if (rd_entry.total > thr_reg && !rd_entry.flag)
        begin
            new_flag = 1'b1;
        end
        else if (rd_entry.total < (thr_reg >> 1) && rd_entry.flag)
        begin
            new_flag = 1'b0;
        end
        else
        begin
            new_flag = rd_entry.flag;
        end
    end

    assign samples.ready = (state_reg == mped_pkg::S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        sweep_cnt_next = sweep_cnt_reg;
        ch_next        = ch_reg;
        rep_idx_next   = rep_idx_reg;
        smp_next       = smp_reg;
        vld_next       = vld_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !results.ready;
        kind_next      = kind_reg;
        chan_next      = chan_reg;
        smp_out_next   = smp_out_reg;
        total_out_next = total_out_reg;
        det_next       = det_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_waddr      = ch_reg;
        mem_wdata      = cur_reg;

        case (state_reg)
            mped_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    ch_next  = ptr_reg;
                    smp_next = mask_reg[mped_pkg::CHAN_W'(ptr_reg)] ? samples.sample : '0;
                    state_next = mped_pkg::S_RD;
                end
            end
            mped_pkg::S_RD:
            begin
                cur_next = rd_entry;
                if (smp_reg > rd_entry.peak_high)
                begin
                    cur_next.peak_high = smp_reg;
                end
                if (smp_reg < rd_entry.peak_low)
                begin
                    cur_next.peak_low = smp_reg;
                end
                state_next = mped_pkg::S_CALC;
            end
            mped_pkg::S_CALC:
            begin
                if (out_free)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = ch_reg;
                    mem_wdata       = cur_reg;
                    mem_wdata.total = sum_sat;
                    vld_next[ch_reg] = 1'b1;
                    out_valid_next = 1'b1;
                    kind_next      = mped_pkg::KIND_ECHO;
                    chan_next      = mped_pkg::CHAN_W'(ch_reg);
                    smp_out_next   = smp_reg;
                    total_out_next = '0;
                    det_next       = cur_reg.flag;
                    last_next      = !period_end;
                    ptr_next       = wrap ? '0 : ch_reg + 1'b1;
                    if (wrap)
                    begin
                        sweep_cnt_next = period_end ? '0 : sweep_inc;
                    end
                    rep_idx_next = '0;
                    state_next   = period_end ? mped_pkg::S_REP_RD : mped_pkg::S_IDLE;
                end
            end
            mped_pkg::S_REP_RD:
            begin
                state_next = mped_pkg::S_REP;
            end
            mped_pkg::S_REP:
            begin
                if (out_free)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = rep_idx_reg;
                    mem_wdata      = cleared;
                    mem_wdata.flag = new_flag;
                    vld_next[rep_idx_reg] = 1'b1;
                    out_valid_next = 1'b1;
                    kind_next      = mped_pkg::KIND_REPORT;
                    chan_next      = mped_pkg::CHAN_W'(rep_idx_reg);
                    smp_out_next   = '0;
                    total_out_next = rd_entry.total;
                    det_next       = new_flag;
                    last_next      = (rep_idx_reg == mped_pkg::LAST_CH);
                    if (rep_idx_reg == mped_pkg::LAST_CH)
                    begin
                        state_next = mped_pkg::S_IDLE;
                    end
                    else
                    begin
                        rep_idx_next = rep_idx_reg + 1'b1;
                        state_next   = mped_pkg::S_REP_RD;
                    end
                end
            end
            default:
            begin
                state_next = mped_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mped_pkg::S_IDLE;
            thr_reg       <= mped_pkg::THRESHOLD_RESET;
            mask_reg      <= mped_pkg::ENABLE_MASK_RESET;
            sweeps_reg    <= mped_pkg::SWEEPS_RESET;
            ptr_reg       <= '0;
            sweep_cnt_reg <= '0;
            ch_reg        <= '0;
            rep_idx_reg   <= '0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            sweep_cnt_reg <= sweep_cnt_next;
            ch_reg        <= ch_next;
            rep_idx_reg   <= rep_idx_next;
            vld_reg       <= vld_next;
            rd_vld_reg    <= vld_reg[mem_raddr];
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    mped_pkg::CFG_THRESHOLD:   thr_reg    <= cfg_data;
                    mped_pkg::CFG_ENABLE_MASK: mask_reg   <= cfg_data[15:0];
                    mped_pkg::CFG_SWEEPS:      sweeps_reg <= cfg_data[mped_pkg::SWEEP_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg       <= smp_next;
        cur_reg       <= cur_next;
        kind_reg      <= kind_next;
        chan_reg      <= chan_next;
        smp_out_reg   <= smp_out_next;
        total_out_reg <= total_out_next;
        det_reg       <= det_next;
        last_reg      <= last_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.kind         = kind_reg;
    assign results.channel      = chan_reg;
    assign results.sample_out   = smp_out_reg;
    assign results.period_total = total_out_reg;
    assign results.detected     = det_reg;
    assign results.last         = last_reg;

`ifndef ASSERT_OFF
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= mped_pkg::LAST_CH)
        else $error("Channel pointer left the channel range.");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == mped_pkg::S_CALC || state_reg == mped_pkg::S_REP))
        else $error("State RAM written outside an update or report step.");

    a_period_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mped_pkg::S_CALC && out_free && period_end)
        |=> (sweep_cnt_reg == '0 && state_reg == mped_pkg::S_REP_RD))
        else $error("Period end did not start the report pass.");

    a_last_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mped_pkg::S_REP && out_free && rep_idx_reg == mped_pkg::LAST_CH)
        |=> (state_reg == mped_pkg::S_IDLE && results.valid && results.last))
        else $error("Final report beat did not end the report pass.");
`endif

endmodule

`default_nettype wire

// ===== src/mped_ram.sv =====
`default_nettype none

module mped_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ===== verif/energy_detector_checker.sv =====
`timescale 1ns / 100ps

module energy_detector_checker
    import mped_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mped_in_if                    samples,
    mped_out_if                   results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    failures,
    output int                    outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                       kind;
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample_out;
        logic [TOTAL_W-1:0]         period_total;
        logic                       detected;
        logic                       last;
    } detector_beat_t;

    logic signed [SAMPLE_W-1:0] ch_max [CHANNELS];
    logic signed [SAMPLE_W-1:0] ch_min [CHANNELS];
    logic [TOTAL_W-1:0]         ch_energy [CHANNELS];
    logic                       ch_active [CHANNELS];
    int unsigned                due_channel;
    int unsigned                sweeps_done;

    logic [TOTAL_W-1:0] threshold_reg;
    logic [15:0]        enable_reg;
    logic [SWEEP_W-1:0] sweeps_reg;

    detector_beat_t expected_beats [$];
    int             mismatch_count = 0;

    task automatic clear_period_state();
        for (int c = 0; c < CHANNELS; c++)
        begin
            ch_max[c]    = PEAK_HIGH_RESET;
            ch_min[c]    = PEAK_LOW_RESET;
            ch_energy[c] = '0;
        end
    endtask

    task automatic reset_detector_state();
        threshold_reg = THRESHOLD_RESET;
        enable_reg    = ENABLE_MASK_RESET;
        sweeps_reg    = SWEEPS_RESET;
        clear_period_state();
        for (int c = 0; c < CHANNELS; c++)
        begin
            ch_active[c] = 1'b0;
        end
        due_channel = 0;
        sweeps_done = 0;
        expected_beats.delete();
    endtask

    task automatic apply_register_write(input logic [CFG_IDX_W-1:0] index,
                                        input logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_THRESHOLD:   threshold_reg = data[TOTAL_W-1:0];
            CFG_ENABLE_MASK: enable_reg = data[15:0];
            CFG_SWEEPS:      sweeps_reg = data[SWEEP_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic predict_sample_beats(input logic signed [SAMPLE_W-1:0] raw);
        detector_beat_t              echo;
        detector_beat_t              report;
        logic signed [SAMPLE_W-1:0]  gated;
        int unsigned                 ch;
        int                          span;
        int unsigned                 sum;
        ch = due_channel;
        gated = enable_reg[ch] ? raw : '0;
        if (gated > ch_max[ch])
            ch_max[ch] = gated;
        if (gated < ch_min[ch])
            ch_min[ch] = gated;
        span = (ch_max[ch] >= ch_min[ch]) ? int'(ch_max[ch]) - int'(ch_min[ch]) : 0;
        sum = int'(ch_energy[ch]) + span;
        ch_energy[ch] = (sum > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(sum);

        echo.kind         = KIND_ECHO;
        echo.channel      = CHAN_W'(ch);
        echo.sample_out   = gated;
        echo.period_total = '0;
        echo.detected     = ch_active[ch];
        echo.last         = 1'b1;

        due_channel = (ch == CHANNELS - 1) ? 0 : ch + 1;
        if (due_channel != 0)
        begin
            expected_beats.push_back(echo);
            return;
        end
        if (sweeps_done < SWEEP_MAX)
            sweeps_done++;
        if (sweeps_done < sweeps_reg)
        begin
            expected_beats.push_back(echo);
            return;
        end

        // The sweep that closes a period puts one report beat per channel behind the echo.
        sweeps_done = 0;
        echo.last = 1'b0;
        expected_beats.push_back(echo);
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (ch_energy[c] > threshold_reg && !ch_active[c])
                ch_active[c] = 1'b1;
            else if (ch_energy[c] < (threshold_reg >> 1) && ch_active[c])
                ch_active[c] = 1'b0;
            report.kind         = KIND_REPORT;
            report.channel      = CHAN_W'(c);
            report.sample_out   = '0;
            report.period_total = ch_energy[c];
            report.detected     = ch_active[c];
            report.last         = (c == CHANNELS - 1);
            expected_beats.push_back(report);
        end
        clear_period_state();
    endtask

    task automatic check_result_beat();
        detector_beat_t want;
        if (expected_beats.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected beat: kind=%0d channel=%0d sample_out=%0d total=%0d det=%0d last=%0d",
                         results.kind, results.channel, results.sample_out,
                         results.period_total, results.detected, results.last);
            return;
        end
        want = expected_beats.pop_front();
        if (results.kind !== want.kind || results.channel !== want.channel
                || results.sample_out !== want.sample_out
                || results.period_total !== want.period_total
                || results.detected !== want.detected || results.last !== want.last)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
            begin
                $display("mismatch at %0t: expected kind=%0d channel=%0d sample_out=%0d total=%0d det=%0d last=%0d",
                         $realtime, want.kind, want.channel, want.sample_out,
                         want.period_total, want.detected, want.last);
                $display("                  got kind=%0d channel=%0d sample_out=%0d total=%0d det=%0d last=%0d",
                         results.kind, results.channel, results.sample_out,
                         results.period_total, results.detected, results.last);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_detector_state();
        end
        else
        begin
            if (results.valid && results.ready)
                check_result_beat();
            if (samples.valid && samples.ready)
                predict_sample_beats(samples.sample);
            if (cfg_we)
                apply_register_write(cfg_index, cfg_data);
        end
        outstanding <= expected_beats.size();
        failures <= mismatch_count;
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import mped_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    localparam logic [CFG_IDX_W-1:0]     CFG_UNUSED = 2'd3;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 17;
    localparam int PRESSURE_ITEMS = 24;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  start_hold;
    int                    send_idle_pct = 0;
    int                    stall_pct = 0;
    int                    failures;
    int                    outstanding;

    mped_in_if  samples_if ();
    mped_out_if results_if ();

    multichannel_peak_energy_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    energy_detector_checker energy_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples_if),
        .results     (results_if),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // A pulse on start_hold makes the receiver refuse every beat for a long stretch.
    initial
    begin
        int hold_left;
        hold_left = 0;
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (start_hold)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else
            begin
                results_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return SAMPLE_W'($signed($urandom_range(16)) - 8);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 74; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 74; end
            IDLE_BOTH:     begin send_idle_pct = 31; stall_pct = 31; end
            default:       ;
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid <= 1'b1;
        samples_if.sample <= value;
        do
            @(posedge clk);
        while (!samples_if.ready);
    endtask

    // The sender stays quiet until every expected beat has been taken and the report pass is over.
    task automatic wait_idle();
        samples_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned sweeps;
        samples_if.valid <= 1'b0;
        samples_if.sample <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_THRESHOLD;
        cfg_data <= '0;
        start_hold <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // The reset settings leave the first period open, so lowering the sweep count ends it.
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        wait_idle();
        write_reg(CFG_SWEEPS, 0);
        write_reg(CFG_ENABLE_MASK, 'hFFFF);
        write_reg(CFG_THRESHOLD, 0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        wait_idle();

        write_reg(CFG_SWEEPS, 2);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        wait_idle();

        write_reg(CFG_UNUSED, 'hFFFFFF);
        write_reg(CFG_THRESHOLD, 'hFFFFFF);
        repeat (4) send_sample('0);
        wait_idle();

        write_reg(CFG_ENABLE_MASK, 'hFFFE);
        write_reg(CFG_THRESHOLD, 100);
        send_sample(1);
        send_sample(-1);
        send_sample(-1);
        send_sample(1);
        wait_idle();

        write_reg(CFG_ENABLE_MASK, 0);
        send_sample(16'sd12345);
        send_sample(-16'sd12345);
        wait_idle();

        write_reg(CFG_ENABLE_MASK, 'hFFFF);
        write_reg(CFG_SWEEPS, CFG_DATA_W'(SWEEP_MAX));
        repeat (6) send_sample(random_sample());
        wait_idle();
        write_reg(CFG_SWEEPS, 1);
        repeat (2) send_sample(random_sample());
        wait_idle();

        set_idling(IDLE_NONE);
        write_reg(CFG_THRESHOLD, 60000);
        write_reg(CFG_SWEEPS, 2);
        start_hold <= 1'b1;
        @(posedge clk);
        start_hold <= 1'b0;
        repeat (PRESSURE_ITEMS) send_sample(random_sample());
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            sweeps = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3, 1);
            write_reg(CFG_SWEEPS, CFG_DATA_W'(sweeps));
            write_reg(CFG_ENABLE_MASK,
                      CFG_DATA_W'(($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom)));
            case ($urandom_range(5))
                0:       write_reg(CFG_THRESHOLD, 0);
                1:       write_reg(CFG_THRESHOLD, 'hFFFFFF);
                default: write_reg(CFG_THRESHOLD,
                                   CFG_DATA_W'($urandom_range((sweeps + 1) * 60000)));
            endcase
            set_idling(idle_mode_t'(phase % 4));
            repeat (PHASE_ITEMS) send_sample(random_sample());
            wait_idle();
        end

        if (failures == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mped_pkg.sv
src/mped_in_if.sv
src/mped_out_if.sv
src/mped_ram.sv
src/multichannel_peak_energy_detector.sv
verif/energy_detector_checker.sv
verif/testbench.sv
